// ===== sv/kbrce_pkg.sv =====
// ----------------------------------------------------------------------------
// kbrce_pkg
// Shared constants and controller/datapath interface types for the keyboard
// report change event unit.
// ----------------------------------------------------------------------------
package kbrce_pkg;

  localparam int MOD_BITS      = 8;   // modifier bits in a report
  localparam int MOD_W         = 3;   // bits of a modifier bit index
  localparam int IN_SLOTS      = 6;   // key slots on the input word
  localparam int SLOT_W        = 3;   // bits of a slot index
  localparam int CODE_W        = 8;   // usage code width
  localparam int KEY_SLOTS_DEF = 6;   // default number of compared slots
  localparam int MAX_STEPS     = MOD_BITS + 2 * IN_SLOTS;
  localparam int STEP_W        = 5;   // holds 0 .. MAX_STEPS-1

  typedef logic [IN_SLOTS-1:0][CODE_W-1:0] slots_t;

  // controller -> datapath
  typedef struct packed {
    logic              load;     // capture a new report, clear the held event
    logic              capture;  // hold the event found at the current step
    logic              emit;     // move the held event into the output register
    logic              last;     // mark the emitted event as final
    logic              commit;   // new report replaces the stored one
    logic [STEP_W-1:0] step;     // scan position
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;       // current step yields an event
    logic held;      // an event waits in the hold register
    logic out_free;  // output register can take a word this cycle
  } status_t;

endpackage

// ===== sv/keyboard_report_change_events_unit.sv =====
// ----------------------------------------------------------------------------
// keyboard_report_change_events_unit
// A new report is accepted only in idle, once the previous scan has ended;
//   a stalled output word holds the scan in place.
// The scan walks one position per cycle, unless the output stalls, through a single comparison unit.
// Reset clears the stored report (no modifiers, all slots empty) and drops
//   any pending output word.
// ----------------------------------------------------------------------------
//
// Operation:
//   A report is latched on accept. The controller then steps through
//   the eight modifier bits, the N old slots (releases) and the N new slots
//   (presses). At each position the datapath decides whether an event
//   exists; a found event is held for one more find so that the final event
//   of the report can be marked. At the end of the scan the held event goes
//   out with last_event set and the new report replaces the stored one.
//   Reports with no change produce no word at all.
//
module keyboard_report_change_events_unit #(
  parameter int KEY_SLOTS = kbrce_pkg::KEY_SLOTS_DEF  // compared slots, 1..6
) (
  input  logic       clk,
  input  logic       rst,
  // report channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] modifier_bits,
  input  logic [7:0] slot0,
  input  logic [7:0] slot1,
  input  logic [7:0] slot2,
  input  logic [7:0] slot3,
  input  logic [7:0] slot4,
  input  logic [7:0] slot5,
  // event channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] key_code,
  output logic       is_modifier,
  output logic       pressed,
  output logic       last_event
);

  kbrce_pkg::cmd_t    cmd;
  kbrce_pkg::status_t status;

  // Sequencer: owns the scan position, the input handshake and the emit decisions.
  kbrce_ctrl #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: report storage, comparison, hold stage and output word.
  kbrce_dpath #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .modifier_bits (modifier_bits),
    .slot0         (slot0),
    .slot1         (slot1),
    .slot2         (slot2),
    .slot3         (slot3),
    .slot4         (slot4),
    .slot5         (slot5),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .key_code      (key_code),
    .is_modifier   (is_modifier),
    .pressed       (pressed),
    .last_event    (last_event)
  );

endmodule

// ===== sv/kbrce_dpath.sv =====
// ----------------------------------------------------------------------------
// kbrce_dpath
// Report registers, per-step event decode, one-event hold stage and the
// output register.
// ----------------------------------------------------------------------------
module kbrce_dpath #(
  parameter int KEY_SLOTS = kbrce_pkg::KEY_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    modifier_bits,
  input  logic [7:0]                    slot0,
  input  logic [7:0]                    slot1,
  input  logic [7:0]                    slot2,
  input  logic [7:0]                    slot3,
  input  logic [7:0]                    slot4,
  input  logic [7:0]                    slot5,
  input  kbrce_pkg::cmd_t               cmd,
  output kbrce_pkg::status_t            status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kbrce_pkg::CODE_W-1:0]  key_code,
  output logic                          is_modifier,
  output logic                          pressed,
  output logic                          last_event
);

  localparam int NSLOT = (KEY_SLOTS > kbrce_pkg::IN_SLOTS) ? kbrce_pkg::IN_SLOTS :
                         (KEY_SLOTS < 1) ? 1 : KEY_SLOTS;
  localparam logic [kbrce_pkg::STEP_W-1:0] REL_BEGIN =
    kbrce_pkg::STEP_W'(kbrce_pkg::MOD_BITS);
  localparam logic [kbrce_pkg::STEP_W-1:0] PRS_BEGIN =
    kbrce_pkg::STEP_W'(kbrce_pkg::MOD_BITS + NSLOT);

  logic [7:0]                     prev_mods;
  kbrce_pkg::slots_t              prev_slots;
  logic [7:0]                     cur_mods;
  kbrce_pkg::slots_t              cur_slots;
  logic                           held;
  logic [kbrce_pkg::CODE_W-1:0]   hold_code;
  logic                           hold_mod;
  logic                           hold_press;

  logic [7:0]                     delta;
  logic [kbrce_pkg::SLOT_W-1:0]   sel;
  logic [kbrce_pkg::CODE_W-1:0]   ev_code;
  logic                           ev_mod;
  logic                           ev_press;
  logic                           ev_hit;

  function automatic logic holds(input kbrce_pkg::slots_t s,
                                 input logic [kbrce_pkg::CODE_W-1:0] code);
    logic found;
    found = 1'b0;
    for (int j = 0; j < NSLOT; j++) begin
      if (s[j] == code) found = 1'b1;
    end
    return found;
  endfunction

  assign delta = cur_mods ^ prev_mods;

  // Decode one scan position: modifier bits, then releases, then presses.
  always_comb begin
    sel      = '0;
    ev_code  = '0;
    ev_mod   = 1'b0;
    ev_press = 1'b0;
    ev_hit   = 1'b0;
    if (cmd.step < REL_BEGIN) begin
      ev_mod   = 1'b1;
      ev_code  = kbrce_pkg::CODE_W'(cmd.step[kbrce_pkg::MOD_W-1:0]);
      ev_hit   = delta[cmd.step[kbrce_pkg::MOD_W-1:0]];
      ev_press = cur_mods[cmd.step[kbrce_pkg::MOD_W-1:0]];
    end else if (cmd.step < PRS_BEGIN) begin
      sel     = kbrce_pkg::SLOT_W'(cmd.step - REL_BEGIN);
      ev_code = prev_slots[sel];
      ev_hit  = (ev_code != '0) && !holds(cur_slots, ev_code);
    end else begin
      sel      = kbrce_pkg::SLOT_W'(cmd.step - PRS_BEGIN);
      ev_code  = cur_slots[sel];
      ev_hit   = (ev_code != '0) && !holds(prev_slots, ev_code);
      ev_press = 1'b1;
    end
  end

  assign status.hit      = ev_hit;
  assign status.held     = held;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mods  <= '0;
      prev_slots <= '0;
      held       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        cur_mods  <= modifier_bits;
        cur_slots <= {slot5, slot4, slot3, slot2, slot1, slot0};
        held      <= 1'b0;
      end
      if (cmd.capture) begin
        hold_code  <= ev_code;
        hold_mod   <= ev_mod;
        hold_press <= ev_press;
        held       <= 1'b1;
      end else if (cmd.emit) begin
        held <= 1'b0;
      end
      if (cmd.emit) begin
        key_code    <= hold_code;
        is_modifier <= hold_mod;
        pressed     <= hold_press;
        last_event  <= cmd.last;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        prev_mods  <= cur_mods;
        prev_slots <= cur_slots;
      end
    end
  end

  a_emit_needs_held: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> held)
    else $error("emit without a held event");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.emit)
    else $error("output word overwritten while stalled");

  a_mod_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_modifier) |-> (key_code < kbrce_pkg::CODE_W'(kbrce_pkg::MOD_BITS)))
    else $error("modifier event carries an out-of-range bit index");

endmodule

// ===== sv/kbrce_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbrce_ctrl
// Sequencer: accept a report, walk the scan positions, flush the final event.
// ----------------------------------------------------------------------------
module kbrce_ctrl #(
  parameter int KEY_SLOTS = kbrce_pkg::KEY_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  kbrce_pkg::status_t status,
  output kbrce_pkg::cmd_t    cmd
);

  localparam int NSLOT = (KEY_SLOTS > kbrce_pkg::IN_SLOTS) ? kbrce_pkg::IN_SLOTS :
                         (KEY_SLOTS < 1) ? 1 : KEY_SLOTS;
  localparam logic [kbrce_pkg::STEP_W-1:0] LAST_STEP =
    kbrce_pkg::STEP_W'(kbrce_pkg::MOD_BITS + 2 * NSLOT - 1);

  typedef enum logic [1:0] {IDLE, SCAN, FLUSH} state_t;

  state_t                        state;
  logic [kbrce_pkg::STEP_W-1:0]  step;
  logic                          stall;

  assign in_ready = (state == IDLE);
  assign stall    = status.hit && status.held && !status.out_free;

  always_comb begin
    cmd        = '0;
    cmd.step   = step;
    case (state)
      IDLE: begin
        cmd.load = in_valid;
      end
      SCAN: begin
        cmd.capture = status.hit && !stall;
        cmd.emit    = status.hit && status.held && !stall;
      end
      FLUSH: begin
        cmd.emit   = status.held && status.out_free;
        cmd.last   = 1'b1;
        cmd.commit = !status.held || status.out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            step  <= '0;
            state <= SCAN;
          end
        end
        SCAN: begin
          if (!stall) begin
            if (step == LAST_STEP) begin
              state <= FLUSH;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        FLUSH: begin
          if (cmd.commit) state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> (step <= LAST_STEP))
    else $error("scan position past the last step");

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == SCAN) && (step == '0))
    else $error("report load did not start a scan at position zero");

  a_commit_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == IDLE))
    else $error("stored report replaced without returning to idle");

endmodule
